[rtl/core/conic_parametric_point_generator_macros.svh]
// Assertion macros used by the conic point generator top level.
`ifndef CONIC_PARAMETRIC_POINT_GENERATOR_MACROS_SVH
`define CONIC_PARAMETRIC_POINT_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CPPG_ASSERT_ALWAYS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/cppg_pkg.sv]
// Types and constants shared by the conic point generator modules.
package cppg_pkg;

	localparam int DIV_BITS = 45;
	localparam int MAG_W    = 63;
	localparam int DEN_W    = 32;
	localparam int UV_W     = 46;

	localparam logic signed [UV_W-1:0] UV_LIMIT = 46'sd17592186044416;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

	localparam logic [1:0] KIND_ELLIPSE   = 2'd0;
	localparam logic [1:0] KIND_HYPERBOLA = 2'd1;
	localparam logic [1:0] KIND_PARABOLA  = 2'd2;

	localparam logic [2:0] REG_CURVE_KIND = 3'd0;
	localparam logic [2:0] REG_CENTER_X   = 3'd1;
	localparam logic [2:0] REG_CENTER_Y   = 3'd2;
	localparam logic [2:0] REG_SEMI_A     = 3'd3;
	localparam logic [2:0] REG_SEMI_B     = 3'd4;
	localparam logic [2:0] REG_COS_ROT    = 3'd5;
	localparam logic [2:0] REG_SIN_ROT    = 3'd6;

	localparam logic [31:0] ARC_TABLE [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic                   bypass;
		logic signed [UV_W-1:0] bypass_val;
		logic [MAG_W-1:0]       mag;
		logic [DEN_W-1:0]       dmag;
		logic                   neg;
		logic                   dzero;
		logic                   bad;
	} cppg_div_in_t;

endpackage

[rtl/core/cppg_cordic.sv]
// Pipelined rotation-mode CORDIC giving sine and cosine of a binary angle in Q2.30.
module cppg_cordic #(
	parameter int ANGLE_WIDTH   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [15:0]        angle,
	output logic               out_valid,
	output logic signed [31:0] cos_q30,
	output logic signed [31:0] sin_q30
);
	import cppg_pkg::*;

	localparam int AW = (ANGLE_WIDTH < 1) ? 1 : (ANGLE_WIDTH > 32) ? 32 : ANGLE_WIDTH;
	localparam int NS = (CORDIC_STAGES < 1) ? 1 : (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam logic [31:0] AMASK = (AW == 32) ? 32'hFFFFFFFF : 32'((64'd1 << AW) - 64'd1);

	logic [31:0] t;
	logic [31:0] tt;
	logic [1:0]  quad;
	logic        exact;
	logic        neg;

	logic              vld_s   [NS+1];
	logic signed [33:0] x_s    [NS+1];
	logic signed [33:0] y_s    [NS+1];
	logic signed [33:0] z_s    [NS+1];
	logic [1:0]        quad_s  [NS+1];
	logic              exact_s [NS+1];
	logic              neg_s   [NS+1];

	assign t     = (32'(angle) & AMASK) << (32 - AW);
	assign quad  = t[31:30];
	assign exact = (t[29:0] == 30'd0);
	assign neg   = (quad == 2'd1) || (quad == 2'd2);
	// Second and third quadrants are folded by a half turn; the pair is negated at the end.
	assign tt    = neg ? (t - 32'h80000000) : t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]     <= CORDIC_START;
			y_s[0]     <= 34'sd0;
			z_s[0]     <= signed'({{2{tt[31]}}, tt});
			quad_s[0]  <= quad;
			exact_s[0] <= exact;
			neg_s[0]   <= neg;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [33:0] arc;

		assign dx  = x_s[i] >>> i;
		assign dy  = y_s[i] >>> i;
		assign arc = signed'({2'b00, ARC_TABLE[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][33]) begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - arc;
				end else begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + arc;
				end
				quad_s[i+1]  <= quad_s[i];
				exact_s[i+1] <= exact_s[i];
				neg_s[i+1]   <= neg_s[i];
			end
		end
	end

	assign out_valid = vld_s[NS];

	always_comb begin
		if (exact_s[NS]) begin
			case (quad_s[NS])
				2'd0: begin
					cos_q30 = ONE_Q30;
					sin_q30 = 32'sd0;
				end
				2'd1: begin
					cos_q30 = 32'sd0;
					sin_q30 = ONE_Q30;
				end
				2'd2: begin
					cos_q30 = -ONE_Q30;
					sin_q30 = 32'sd0;
				end
				default: begin
					cos_q30 = 32'sd0;
					sin_q30 = -ONE_Q30;
				end
			endcase
		end else if (neg_s[NS]) begin
			cos_q30 = 32'(-x_s[NS]);
			sin_q30 = 32'(-y_s[NS]);
		end else begin
			cos_q30 = 32'(x_s[NS]);
			sin_q30 = 32'(y_s[NS]);
		end
	end

endmodule

[rtl/core/cppg_div.sv]
// Pipelined restoring divider lane with saturation to the curve coordinate limit.
module cppg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  cppg_pkg::cppg_div_in_t        din,
	output logic                          out_valid,
	output logic signed [cppg_pkg::UV_W-1:0] value,
	output logic                          bad
);
	import cppg_pkg::*;

	logic                vld_s  [DIV_BITS+1];
	cppg_div_in_t        side_s [DIV_BITS+1];
	logic [DEN_W-1:0]    rem_s  [DIV_BITS+1];
	logic [DIV_BITS-1:0] q_s    [DIV_BITS+1];
	logic                ovf_s  [DIV_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	// The high numerator bits start the remainder; if they already reach the
	// divisor the quotient needs more bits than are kept and must saturate.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= din;
			rem_s[0]  <= DEN_W'(din.mag[MAG_W-1:DIV_BITS]);
			ovf_s[0]  <= (DEN_W'(din.mag[MAG_W-1:DIV_BITS]) >= din.dmag);
			q_s[0]    <= '0;
		end
	end

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
		localparam int BIT = DIV_BITS - 1 - k;
		logic [DEN_W:0]      rs;
		logic                ge;
		logic [DIV_BITS-1:0] nq;

		assign rs = {rem_s[k], side_s[k].mag[BIT]};
		assign ge = (rs >= {1'b0, side_s[k].dmag});

		always_comb begin
			nq      = q_s[k];
			nq[BIT] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				q_s[k+1]    <= nq;
				rem_s[k+1]  <= ge ? DEN_W'(rs - {1'b0, side_s[k].dmag}) : rs[DEN_W-1:0];
			end
		end
	end

	logic signed [UV_W-1:0] q_ext;
	logic                   big;
	cppg_div_in_t           fin;

	assign fin       = side_s[DIV_BITS];
	assign q_ext     = signed'(UV_W'(q_s[DIV_BITS]));
	assign big       = ovf_s[DIV_BITS] || (q_ext > UV_LIMIT);
	assign out_valid = vld_s[DIV_BITS];

	always_comb begin
		if (fin.bypass) begin
			value = fin.bypass_val;
			bad   = fin.bad;
		end else if (fin.dzero) begin
			bad = 1'b1;
			if (fin.mag == '0) begin
				value = '0;
			end else begin
				value = fin.neg ? -UV_LIMIT : UV_LIMIT;
			end
		end else if (big) begin
			bad   = 1'b1;
			value = fin.neg ? -UV_LIMIT : UV_LIMIT;
		end else begin
			bad   = fin.bad;
			value = fin.neg ? -q_ext : q_ext;
		end
	end

endmodule

[rtl/core/conic_parametric_point_generator.sv]
// Top level of the conic point generator: configuration registers and point pipeline.
// The block takes one parameter angle per cycle while angle_stall is low and returns one
// rotated, translated point of the configured ellipse, hyperbola or parabola per item, in
// order. The pipeline holds CORDIC_STAGES + 1 register stages of the sine/cosine CORDIC,
// two stages for the axis products, 46 stages of the 45-bit restoring divider used by
// the hyperbola and parabola, and four stages for rotation, translation and saturation.
// The pipeline advances as a whole; a stalled result holds every stage, so items are
// never lost. Registers must only be written while no item is in flight. point_invalid
// flags a zero divisor, a saturated coordinate or the reserved curve kind.
`include "conic_parametric_point_generator_macros.svh"

module conic_parametric_point_generator #(
	parameter int COORD_WIDTH   = 32,
	parameter int ANGLE_WIDTH   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               angle_valid,
	output logic               angle_stall,
	input  logic [15:0]        angle,
	output logic               point_valid,
	input  logic               point_stall,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic               point_invalid
);
	import cppg_pkg::*;

	localparam int CW = (COORD_WIDTH < 16) ? 16 : (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
	localparam logic signed [49:0] HI = (50'sd1 <<< (CW - 1)) - 50'sd1;
	localparam logic signed [49:0] LO = -(50'sd1 <<< (CW - 1));
	localparam logic signed [31:0] SC_BOUND = 32'sd1074790400;

	// Configuration registers.
	logic [1:0]         curve_kind_q;
	logic signed [31:0] center_x_q;
	logic signed [31:0] center_y_q;
	logic [30:0]        semi_a_q;
	logic [30:0]        semi_b_q;
	logic signed [17:0] cos_rot_q;
	logic signed [17:0] sin_rot_q;

	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_kind_q <= KIND_ELLIPSE;
			center_x_q   <= 32'sd0;
			center_y_q   <= 32'sd0;
			semi_a_q     <= 31'd65536;
			semi_b_q     <= 31'd65536;
			cos_rot_q    <= 18'sd65536;
			sin_rot_q    <= 18'sd0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_CURVE_KIND: curve_kind_q <= pwdata[1:0];
				REG_CENTER_X:   center_x_q   <= signed'(pwdata);
				REG_CENTER_Y:   center_y_q   <= signed'(pwdata);
				REG_SEMI_A:     semi_a_q     <= pwdata[30:0];
				REG_SEMI_B:     semi_b_q     <= pwdata[30:0];
				REG_COS_ROT:    cos_rot_q    <= signed'(pwdata[17:0]);
				REG_SIN_ROT:    sin_rot_q    <= signed'(pwdata[17:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_CURVE_KIND: prdata = {30'd0, curve_kind_q};
			REG_CENTER_X:   prdata = center_x_q;
			REG_CENTER_Y:   prdata = center_y_q;
			REG_SEMI_A:     prdata = {1'b0, semi_a_q};
			REG_SEMI_B:     prdata = {1'b0, semi_b_q};
			REG_COS_ROT:    prdata = 32'(cos_rot_q);
			REG_SIN_ROT:    prdata = 32'(sin_rot_q);
			default:        prdata = 32'd0;
		endcase
	end

	// Whole-pipeline advance: only a held result stops it.
	logic en;
	logic vld_s6;

	assign en          = !(vld_s6 && point_stall);
	assign angle_stall = !en;

	logic               cord_vld;
	logic signed [31:0] cord_cs;
	logic signed [31:0] cord_sn;

	cppg_cordic #(
		.ANGLE_WIDTH  (ANGLE_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (angle_valid),
		.angle    (angle),
		.out_valid(cord_vld),
		.cos_q30  (cord_cs),
		.sin_q30  (cord_sn)
	);

	// Stage 1: sine and cosine.
	logic               vld_s1;
	logic signed [31:0] cs_s1;
	logic signed [31:0] sn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cord_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s1 <= cord_cs;
			sn_s1 <= cord_sn;
		end
	end

	// Stage 2: axis products and divisor.
	logic               vld_s2;
	logic [1:0]         kind_s2;
	logic signed [63:0] prod_u_s2;
	logic signed [63:0] prod_v_s2;
	logic signed [32:0] den_s2;

	logic signed [31:0] mu;
	logic signed [31:0] mv;
	logic signed [31:0] ma;
	logic signed [31:0] mb;
	logic signed [32:0] pden;
	logic signed [32:0] den_c;

	always_comb begin
		ma   = signed'({1'b0, semi_a_q});
		mb   = (curve_kind_q == KIND_PARABOLA) ? ma : signed'({1'b0, semi_b_q});
		mu   = (curve_kind_q == KIND_HYPERBOLA) ? ONE_Q30 : cs_s1;
		mv   = (curve_kind_q == KIND_HYPERBOLA) ? cs_s1 : sn_s1;
		pden = signed'({ONE_Q30[31], ONE_Q30}) + signed'({cs_s1[31], cs_s1});
		case (curve_kind_q)
			KIND_HYPERBOLA: den_c = signed'({sn_s1[31], sn_s1});
			KIND_PARABOLA:  den_c = pden[32] ? 33'sd0 : pden;
			default:        den_c = 33'sd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2   <= curve_kind_q;
			prod_u_s2 <= ma * mu;
			prod_v_s2 <= mb * mv;
			den_s2    <= den_c;
		end
	end

	function automatic cppg_div_in_t make_lane(logic [1:0] kind, logic signed [63:0] prod,
			logic signed [32:0] den);
		cppg_div_in_t r;
		logic         numneg;
		logic [32:0]  dabs;
		r      = '0;
		// The parabola numerator is the negated product.
		numneg = (kind == KIND_PARABOLA) ? (prod > 64'sd0) : prod[63];
		dabs   = den[32] ? 33'(-den) : 33'(den);
		r.mag  = prod[63] ? MAG_W'(-prod) : MAG_W'(prod);
		r.dmag = dabs[DEN_W-1:0];
		r.dzero = (den == 33'sd0);
		r.neg  = r.dzero ? numneg : (numneg ^ den[32]);
		case (kind)
			KIND_ELLIPSE: begin
				r.bypass     = 1'b1;
				r.bypass_val = UV_W'(prod >>> 30);
			end
			KIND_HYPERBOLA, KIND_PARABOLA: ;
			default: begin
				r.bypass     = 1'b1;
				r.bypass_val = '0;
				r.bad        = 1'b1;
			end
		endcase
		return r;
	endfunction

	cppg_div_in_t lane_u_in;
	cppg_div_in_t lane_v_in;

	assign lane_u_in = make_lane(kind_s2, prod_u_s2, den_s2);
	assign lane_v_in = make_lane(kind_s2, prod_v_s2, den_s2);

	logic                   div_u_vld;
	logic                   div_v_vld;
	logic signed [UV_W-1:0] div_u;
	logic signed [UV_W-1:0] div_v;
	logic                   div_u_bad;
	logic                   div_v_bad;

	cppg_div u_div_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.din      (lane_u_in),
		.out_valid(div_u_vld),
		.value    (div_u),
		.bad      (div_u_bad)
	);

	cppg_div u_div_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.din      (lane_v_in),
		.out_valid(div_v_vld),
		.value    (div_v),
		.bad      (div_v_bad)
	);

	// Stage 3: curve point before rotation.
	logic                   vld_s3;
	logic signed [UV_W-1:0] u_s3;
	logic signed [UV_W-1:0] v_s3;
	logic                   bad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= div_u_vld && div_v_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s3   <= div_u;
			v_s3   <= div_v;
			bad_s3 <= div_u_bad || div_v_bad;
		end
	end

	// Stage 4: rotation products.
	logic               vld_s4;
	logic signed [63:0] cu_s4;
	logic signed [63:0] sv_s4;
	logic signed [63:0] su_s4;
	logic signed [63:0] cv_s4;
	logic               bad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cu_s4  <= cos_rot_q * u_s3;
			sv_s4  <= sin_rot_q * v_s3;
			su_s4  <= sin_rot_q * u_s3;
			cv_s4  <= cos_rot_q * v_s3;
			bad_s4 <= bad_s3;
		end
	end

	// Stage 5: rotated sums.
	logic               vld_s5;
	logic signed [64:0] dx_s5;
	logic signed [64:0] dy_s5;
	logic               bad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s5  <= 65'(cu_s4) - 65'(sv_s4);
			dy_s5  <= 65'(su_s4) + 65'(cv_s4);
			bad_s5 <= bad_s4;
		end
	end

	// Stage 6: translation and saturation; this is the output register.
	logic signed [31:0] px_s6;
	logic signed [31:0] py_s6;
	logic               bad_s6;
	logic signed [49:0] sx;
	logic signed [49:0] sy;
	logic signed [31:0] px_c;
	logic signed [31:0] py_c;
	logic               sat_x;
	logic               sat_y;

	always_comb begin
		sx    = 50'(center_x_q) + 50'(dx_s5 >>> 16);
		sy    = 50'(center_y_q) + 50'(dy_s5 >>> 16);
		sat_x = (sx > HI) || (sx < LO);
		sat_y = (sy > HI) || (sy < LO);
		px_c  = (sx > HI) ? 32'(HI) : (sx < LO) ? 32'(LO) : 32'(sx);
		py_c  = (sy > HI) ? 32'(HI) : (sy < LO) ? 32'(LO) : 32'(sy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s6  <= px_c;
			py_s6  <= py_c;
			bad_s6 <= bad_s5 || sat_x || sat_y;
		end
	end

	assign point_valid   = vld_s6;
	assign point_x       = px_s6;
	assign point_y       = py_s6;
	assign point_invalid = bad_s6;

	`CPPG_ASSERT_ALWAYS(a_u_range, vld_s3, (u_s3 <= UV_LIMIT) && (u_s3 >= -UV_LIMIT), "u beyond limit")
	`CPPG_ASSERT_ALWAYS(a_v_range, vld_s3, (v_s3 <= UV_LIMIT) && (v_s3 >= -UV_LIMIT), "v beyond limit")
	`CPPG_ASSERT_ALWAYS(a_sc_range, vld_s1, (cs_s1 <= SC_BOUND) && (cs_s1 >= -SC_BOUND) && (sn_s1 <= SC_BOUND) && (sn_s1 >= -SC_BOUND), "sine or cosine out of range")
	`CPPG_ASSERT_NEXT(a_bad_flows, en && vld_s5 && bad_s5, point_valid && point_invalid, "flag lost")

endmodule

[dv/conic_parametric_point_generator_checker.sv]
// Checker for the conic point generator: tracks the registers, predicts each point and compares.
module conic_parametric_point_generator_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               angle_valid,
	input  logic               angle_stall,
	input  logic [15:0]        angle,
	input  logic               point_valid,
	input  logic               point_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic               point_invalid,
	output int                 mismatches,
	output int                 in_flight,
	output int                 points_seen,
	output int                 flagged_seen
);
	import cppg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint UNIT_Q30 = 64'sd1 << 30;
	localparam longint LIMIT_UV = 64'sd1 << 44;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               invalid;
	} point_t;

	logic [1:0] kind;
	longint     org_x, org_y, axis_a, axis_b, rot_c, rot_s;
	point_t     pending_points[$];

	function automatic longint saturate(input longint v, input longint lo, input longint hi,
			inout bit flag);
		if (v > hi) begin
			flag = 1'b1;
			return hi;
		end
		if (v < lo) begin
			flag = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic longint safe_quotient(input longint num, input longint den,
			inout bit flag);
		if (den == 0) begin
			flag = 1'b1;
			if (num > 0) return LIMIT_UV;
			if (num < 0) return -LIMIT_UV;
			return 0;
		end
		return saturate(num / den, -LIMIT_UV, LIMIT_UV, flag);
	endfunction

	// Quadrant-folded rotation CORDIC giving cosine and sine in Q2.30.
	function automatic void cordic_sincos(input logic [15:0] ang, output longint cosv,
			output longint sinv);
		logic [31:0] turn;
		logic [1:0]  quad;
		longint      z, x, y, dx, dy;
		bit          flip;
		turn = {ang, 16'h0};
		quad = turn[31:30];
		if (turn[29:0] == 30'd0) begin
			cosv = (quad == 2'd0) ? UNIT_Q30 : (quad == 2'd2) ? -UNIT_Q30 : 64'sd0;
			sinv = (quad == 2'd1) ? UNIT_Q30 : (quad == 2'd3) ? -UNIT_Q30 : 64'sd0;
			return;
		end
		flip = (quad == 2'd1) || (quad == 2'd2);
		if (flip)
			turn = turn - 32'h8000_0000;
		z = longint'(signed'(turn));
		x = longint'(CORDIC_START);
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'({32'h0, ARC_TABLE[i]});
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'({32'h0, ARC_TABLE[i]});
			end
		end
		cosv = flip ? -x : x;
		sinv = flip ? -y : y;
	endfunction

	function automatic point_t curve_point(input logic [15:0] ang);
		longint cosv, sinv, u, v, den, px, py;
		bit     bad;
		point_t p;
		bad = 1'b0;
		u = 0;
		v = 0;
		cordic_sincos(ang, cosv, sinv);
		case (kind)
			KIND_ELLIPSE: begin
				u = saturate((axis_a * cosv) >>> 30, -LIMIT_UV, LIMIT_UV, bad);
				v = saturate((axis_b * sinv) >>> 30, -LIMIT_UV, LIMIT_UV, bad);
			end
			KIND_HYPERBOLA: begin
				u = safe_quotient(axis_a * UNIT_Q30, sinv, bad);
				v = safe_quotient(axis_b * cosv, sinv, bad);
			end
			KIND_PARABOLA: begin
				den = UNIT_Q30 + cosv;
				if (den < 0)
					den = 0;
				u = safe_quotient(-(axis_a * cosv), den, bad);
				v = safe_quotient(-(axis_a * sinv), den, bad);
			end
			default: bad = 1'b1;
		endcase
		px = org_x + ((rot_c * u - rot_s * v) >>> 16);
		py = org_y + ((rot_s * u + rot_c * v) >>> 16);
		px = saturate(px, -(64'sd1 << 31), (64'sd1 << 31) - 1, bad);
		py = saturate(py, -(64'sd1 << 31), (64'sd1 << 31) - 1, bad);
		p.x = px[31:0];
		p.y = py[31:0];
		p.invalid = bad;
		return p;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	assign in_flight = pending_points.size();

	always @(posedge clk or negedge arst_n) begin
		point_t want;
		if (!arst_n) begin
			kind <= KIND_ELLIPSE;
			org_x <= 0;
			org_y <= 0;
			axis_a <= 65536;
			axis_b <= 65536;
			rot_c <= 65536;
			rot_s <= 0;
			mismatches <= 0;
			points_seen <= 0;
			flagged_seen <= 0;
			pending_points.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_CURVE_KIND: kind <= pwdata[1:0];
					REG_CENTER_X:   org_x <= longint'(signed'(pwdata));
					REG_CENTER_Y:   org_y <= longint'(signed'(pwdata));
					REG_SEMI_A:     axis_a <= longint'({33'h0, pwdata[30:0]});
					REG_SEMI_B:     axis_b <= longint'({33'h0, pwdata[30:0]});
					REG_COS_ROT:    rot_c <= longint'(signed'(pwdata[17:0]));
					REG_SIN_ROT:    rot_s <= longint'(signed'(pwdata[17:0]));
					default: ;
				endcase
			end
			if (angle_valid && !angle_stall)
				pending_points.push_back(curve_point(angle));
			if (point_valid && !point_stall) begin
				points_seen <= points_seen + 1;
				if (point_invalid)
					flagged_seen <= flagged_seen + 1;
				if (pending_points.size() == 0) begin
					report_mismatch("unexpected point", 1, 0);
				end else begin
					want = pending_points.pop_front();
					if (point_x !== want.x)
						report_mismatch("point_x", point_x, want.x);
					if (point_y !== want.y)
						report_mismatch("point_y", point_y, want.y);
					if (point_invalid !== want.invalid)
						report_mismatch("point_invalid", point_invalid, want.invalid);
				end
			end
		end
	end
endmodule

[dv/conic_parametric_point_generator_test.sv]
// Testbench top for the conic point generator: clock, reset, stimulus and verdict.
module conic_parametric_point_generator_test;
	import cppg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASES = 11;
	localparam int ITEMS_PER_PHASE = 85;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               angle_valid;
	logic               angle_stall;
	logic [15:0]        angle;
	logic               point_valid;
	logic               point_stall;
	logic signed [31:0] point_x, point_y;
	logic               point_invalid;
	int                 mismatches, in_flight, points_seen, flagged_seen;
	int                 cycles;
	bit                 quiet;
	bit                 hold_request;

	conic_parametric_point_generator u_top (.*);

	conic_parametric_point_generator_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d points outstanding", in_flight);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: short random stalls, one long hold-off on request.
	initial begin
		bit long_hold_done;
		long_hold_done = 1'b0;
		point_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !long_hold_done) begin
				point_stall <= 1'b1;
				repeat (300) @(negedge clk);
				point_stall <= 1'b0;
				long_hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				point_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				point_stall <= 1'b0;
			end else begin
				point_stall <= 1'b0;
			end
		end
	end

	// Called just after a falling edge; returns just after a falling edge.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_conic(input logic [1:0] k, input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
			input logic [31:0] s);
		write_reg(REG_CURVE_KIND, {30'h0, k});
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_SEMI_A, a);
		write_reg(REG_SEMI_B, b);
		write_reg(REG_COS_ROT, c);
		write_reg(REG_SIN_ROT, s);
	endtask

	task automatic send_angle(input logic [15:0] ang);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			angle_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		angle <= ang;
		angle_valid <= 1'b1;
		@(posedge clk);
		while (angle_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Quarter turns and their neighbours are the interesting angles.
	function automatic logic [15:0] pick_angle();
		logic [15:0] q;
		if ($urandom_range(0, 5) == 0) begin
			q = 16'($urandom_range(0, 3)) << 14;
			return q + 16'($signed($urandom_range(0, 4)) - 2);
		end
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] pick_rot();
		case ($urandom_range(0, 4))
			0: return 32'sd65536;
			1: return -32'sd65536;
			2: return 32'sd46341;
			3: return 32'sd0;
			default: return 32'($signed($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	task automatic settle();
		angle_valid <= 1'b0;
		wait (in_flight == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [15:0] directed[$];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		angle_valid = 1'b0;
		angle = '0;
		quiet = 1'b0;
		hold_request = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0001,
			16'h3FFF, 16'h4001, 16'h7FFF, 16'h8001, 16'hBFFF, 16'hC001, 16'h2000,
			16'h6000, 16'hA000, 16'hE000, 16'h5555, 16'hAAAA, 16'h1234};
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: ; // reset values: unit circle at the origin
				1: load_conic(KIND_HYPERBOLA, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000,
					32'h0001_8000, 32'sd46341, 32'sd46341);
				2: load_conic(KIND_PARABOLA, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
					32'sd65536, 32'sd0);
				3: load_conic(KIND_ELLIPSE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'h7FFF_FFFF, -32'sd65536, 32'sd65536);
				4: load_conic(KIND_HYPERBOLA, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
					-32'sd65536, -32'sd65536);
				5: load_conic(2'd3, 32'h1234_5678, 32'h8765_4321, 32'h0001_0000,
					32'h0001_0000, 32'sd65536, 32'sd0);
				6: load_conic(KIND_PARABOLA, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
					32'hFFFF_FFFF, 32'sd0, 32'sd65536);
				default: load_conic(2'($urandom_range(0, 2)), 32'($signed($urandom) >>> 6),
					32'($signed($urandom) >>> 6), 32'($urandom_range(0, 32'h00FF_FFFF)),
					32'($urandom_range(0, 32'h00FF_FFFF)), pick_rot(), pick_rot());
			endcase
			if (ph == 0)
				foreach (directed[i])
					send_angle(directed[i]);
			if (ph == 2)
				hold_request = 1'b1;
			if (ph == PHASES - 1)
				quiet = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_angle(pick_angle());
			settle();
		end

		$display("%0d curve points checked over %0d settings, %0d of them flagged invalid",
			points_seen, PHASES, flagged_seen);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
